// File: rtl/core/rcsmpd_pkg.sv
// shared types and constants of the rc-gated motor pwm drive
package rcsmpd_pkg;

    localparam int DUTY_W  = 16;
    localparam int PULSE_W = 16;
    localparam int CMP_W   = 9;

    // radio pulse thresholds in microseconds
    localparam logic [PULSE_W-1:0] PULSE_MIN      = 16'd900;
    localparam logic [PULSE_W-1:0] PULSE_MAX      = 16'd2100;
    localparam logic [PULSE_W-1:0] DEADBAND_LO    = 16'd1200;
    localparam logic [PULSE_W-1:0] DEADBAND_HI    = 16'd1800;
    localparam logic [PULSE_W-1:0] PULSE_NEUTRAL  = 16'd1500;

    // reverse span divisor and fixed-point shift of its reciprocal
    localparam int REV_DIV   = 500;
    localparam int REV_SHIFT = 20;
    localparam int REV_DIFF_W = 10;

    // register map
    localparam logic REG_SAFETY_ENABLE = 1'b0;

    typedef struct packed {
        logic signed [DUTY_W-1:0] duty;
        logic [PULSE_W-1:0]       rc_pulse_us;
        logic                     stop_request;
    } t_drive_request;

    typedef struct packed {
        logic [CMP_W-1:0] compare_forward;
        logic [CMP_W-1:0] compare_backward;
        logic             status;
    } t_drive_result;

endpackage

// File: rtl/core/rcsmpd_cfg.sv
// apb configuration register file of the motor pwm drive
module rcsmpd_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        o_safety_enable
);
    import rcsmpd_pkg::*;

    logic r_safety_enable;
    logic n_safety_enable;
    logic wr_en;

    assign wr_en = psel && penable && pwrite;

    always_comb begin
        n_safety_enable = r_safety_enable;
        if (wr_en && (paddr[2] == REG_SAFETY_ENABLE)) begin
            n_safety_enable = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safety_enable <= 1'b1;
        end else begin
            r_safety_enable <= n_safety_enable;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SAFETY_ENABLE) begin
            prdata = {31'd0, r_safety_enable};
        end
    end

    assign o_safety_enable = r_safety_enable;

endmodule

// File: rtl/core/rcsmpd_core.sv
// compare computation and drive state of the motor pwm drive
module rcsmpd_core #(
    parameter int PWM_PERIOD_TICKS = 320,
    parameter int BAD_PULSE_LIMIT  = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic                       i_safety_enable,
    input  rcsmpd_pkg::t_drive_request i_req,
    output rcsmpd_pkg::t_drive_result  o_result
);
    import rcsmpd_pkg::*;

    localparam int FWD_MAX = PWM_PERIOD_TICKS * 85 / 100;
    localparam int BWD_MAX = PWM_PERIOD_TICKS - FWD_MAX;
    localparam int STOP    = PWM_PERIOD_TICKS / 2;
    localparam int SPAN    = FWD_MAX - BWD_MAX;
    localparam int RSPAN   = STOP - BWD_MAX;
    localparam int CW      = $clog2(PWM_PERIOD_TICKS + 1);
    localparam int CNT_W   = $clog2(BAD_PULSE_LIMIT + 1);
    localparam longint RMUL = (longint'(RSPAN) * (longint'(1) << REV_SHIFT) + REV_DIV - 1)
                              / REV_DIV;
    localparam int RMUL_W  = $clog2(RMUL + 1);

    localparam logic [CW-1:0]        SPAN_V   = CW'(SPAN);
    localparam logic [CW-1:0]        BWD_V    = CW'(BWD_MAX);
    localparam logic [CW-1:0]        STOP_V   = CW'(STOP);
    localparam logic [CW-1:0]        PERIOD_V = CW'(PWM_PERIOD_TICKS);
    localparam logic signed [CW:0]   BWD_S    = (CW+1)'(BWD_MAX);
    localparam logic signed [CW:0]   FWD_S    = (CW+1)'(FWD_MAX);
    localparam logic signed [CW:0]   STOP_S   = (CW+1)'(STOP);
    localparam logic [RMUL_W-1:0]    RMUL_V   = RMUL_W'(RMUL);
    localparam logic [CNT_W-1:0]     LIMIT_V  = CNT_W'(BAD_PULSE_LIMIT);

    logic [CW-1:0]    r_drive_compare;
    logic [CW-1:0]    n_drive_compare;
    logic [CNT_W-1:0] r_bad_count;
    logic [CNT_W-1:0] n_bad_count;
    logic             r_stop_latched;
    logic             n_stop_latched;

    logic [DUTY_W-1:0]          duty_offs;
    logic [DUTY_W+CW-1:0]       duty_prod;
    logic [CW-1:0]              duty_cmp;
    logic [PULSE_W-1:0]         pulse_eff;
    logic [PULSE_W-1:0]         rev_diff_full;
    logic [REV_DIFF_W-1:0]      rev_diff;
    logic [REV_DIFF_W+RMUL_W-1:0] rev_prod;
    logic [CW-1:0]              rev_drop;
    logic signed [CW:0]         rev_cmp;
    logic signed [CW:0]         cand;
    logic                       pulse_bad;
    logic [31:0]                fwd_ext;
    logic [31:0]                bwd_ext;
    logic [CW-1:0]              bwd_cmp;

    // duty + 32768 scaled onto the forward span
    assign duty_offs = {~i_req.duty[DUTY_W-1], i_req.duty[DUTY_W-2:0]};
    assign duty_prod = duty_offs * SPAN_V;
    assign duty_cmp  = BWD_V + duty_prod[DUTY_W +: CW];

    // dead band collapses onto neutral
    assign pulse_bad = (i_req.rc_pulse_us < PULSE_MIN) || (i_req.rc_pulse_us > PULSE_MAX);
    assign pulse_eff = ((i_req.rc_pulse_us > DEADBAND_LO) && (i_req.rc_pulse_us < DEADBAND_HI))
                       ? PULSE_NEUTRAL : i_req.rc_pulse_us;

    // reverse drop = floor(diff * rspan / 500), via exact reciprocal
    assign rev_diff_full = PULSE_NEUTRAL - pulse_eff;
    assign rev_diff      = rev_diff_full[REV_DIFF_W-1:0];
    assign rev_prod      = rev_diff * RMUL_V;
    assign rev_drop      = CW'(rev_prod >> REV_SHIFT);
    assign rev_cmp       = STOP_S - $signed({1'b0, rev_drop});

    always_comb begin
        n_stop_latched = r_stop_latched | i_req.stop_request;
        n_bad_count    = r_bad_count;
        cand           = $signed({1'b0, r_drive_compare});
        if (n_stop_latched) begin
            cand = STOP_S;
        end else if (!i_safety_enable) begin
            cand = $signed({1'b0, duty_cmp});
        end else if (pulse_bad) begin
            if (r_bad_count < LIMIT_V) begin
                n_bad_count = r_bad_count + CNT_W'(1);
            end
            if (n_bad_count >= LIMIT_V) begin
                cand = STOP_S;
            end
        end else begin
            n_bad_count = '0;
            if (pulse_eff <= PULSE_NEUTRAL) begin
                cand = rev_cmp;
            end else begin
                cand = $signed({1'b0, duty_cmp});
            end
        end

        if (cand < BWD_S) begin
            n_drive_compare = BWD_V;
        end else if (cand > FWD_S) begin
            n_drive_compare = CW'(FWD_MAX);
        end else begin
            n_drive_compare = cand[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_compare <= STOP_V;
            r_bad_count     <= '0;
            r_stop_latched  <= 1'b0;
        end else if (i_advance) begin
            r_drive_compare <= n_drive_compare;
            r_bad_count     <= n_bad_count;
            r_stop_latched  <= n_stop_latched;
        end
    end

    // outputs wrap to the 9-bit compare fields
    assign bwd_cmp = PERIOD_V - n_drive_compare;
    assign fwd_ext = 32'(n_drive_compare);
    assign bwd_ext = 32'(bwd_cmp);

    assign o_result.compare_forward  = fwd_ext[CMP_W-1:0];
    assign o_result.compare_backward = bwd_ext[CMP_W-1:0];
    assign o_result.status           = n_stop_latched;

endmodule

// File: rtl/core/rc_safety_motor_pwm_drive.sv
// top level of the rc-gated motor pwm drive
//
// usage: each request on the input channel carries a signed q1.15 duty, the
// latest radio pulse width in microseconds and a force-stop bit. for every
// request the block returns one result with the forward compare, the
// complementary backward compare (period minus forward) and a stop status
// that is set once the force-stop latch is set
// path: a request is held in an input register, the compare logic (two constant
// multiplies, compares and a clamp) works on it there, and the result lands in
// the output register once that register is free to take it
// throughput: one request per cycle while the receiver takes results, limited by the single compare stage
// reset: safety gating on, compare at the stop value, bad pulse count zero,
// stop latch clear, both channels empty
// stall: while the receiver holds off, the result stays in the output register
// and one more request waits in the input register; then input ready drops
// configuration: apb port, safety_enable at byte address 0, pready always high;
// the user writes it only while no request is in flight, the block itself does not enforce it
module rc_safety_motor_pwm_drive #(
    parameter int PWM_PERIOD_TICKS = 320,
    parameter int BAD_PULSE_LIMIT  = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_duty,
    input  logic [15:0]        i_rc_pulse_us,
    input  logic               i_stop_request,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [8:0]         o_compare_forward,
    output logic [8:0]         o_compare_backward,
    output logic               o_status,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rcsmpd_pkg::*;

    logic           r_in_valid;
    t_drive_request r_req;
    logic           r_out_valid;
    t_drive_result  r_result;
    t_drive_result  core_result;
    logic           out_free;
    logic           advance;
    logic           in_take;
    logic           safety_enable;

    // output register can take a new result when empty or being drained
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    rcsmpd_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .o_safety_enable (safety_enable)
    );

    assign pready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req.duty         <= i_duty;
            r_req.rc_pulse_us  <= i_rc_pulse_us;
            r_req.stop_request <= i_stop_request;
        end
    end

    // compare logic and drive state, updated as each request moves on
    rcsmpd_core #(
        .PWM_PERIOD_TICKS (PWM_PERIOD_TICKS),
        .BAD_PULSE_LIMIT  (BAD_PULSE_LIMIT)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_safety_enable (safety_enable),
        .i_req           (r_req),
        .o_result        (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_compare_forward  = r_result.compare_forward;
    assign o_compare_backward = r_result.compare_backward;
    assign o_status           = r_result.status;

endmodule
